### rtl/lrupr_pkg.sv
// Package: shared types, constants and defaults for the LRU page replacement block.
package lrupr_pkg;

  localparam int FRAME_SLOTS_DEF = 8;
  localparam int PAGE_BITS_DEF   = 16;

  localparam int       CFG_DATA_W    = 32;
  localparam int       CFG_ADDR_W    = 3;
  localparam int       FRAMES_W      = 4;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;
  localparam logic     CFG_IDX_FRAMES = 1'b0;   // register index 0, byte address 0

  localparam int SLOT_OUT_W  = 3;
  localparam int FAULT_W     = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } lrupr_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming page request
    logic lookup;   // run the slot search, register the decision
    logic commit;   // update slots, counter and output register
  } lrupr_cmd_t;

endpackage

### rtl/lrupr_ctrl.sv
// Controller: request sequencing and output-valid handling for the LRU engine.
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output lrupr_cmd_t cmd
);

  lrupr_state_t state, state_next;
  logic         out_free;
  logic         s_acc;

  assign out_free = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) state_next = ST_LOOK;
      end
      ST_LOOK: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) state_next = s_acc ? ST_LOOK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_LOOK:   cmd.lookup = 1'b1;
      ST_UPDATE: begin
        s_tready   = out_free;
        cmd.commit = out_free;
      end
      default: s_tready = 1'b0;
    endcase
    cmd.capture = s_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/lrupr_datapath.sv
// Datapath: slot table, recency ages, victim search, fault counter and result register.
module lrupr_datapath
  import lrupr_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PAGE_BITS + FAULT_W + SLOT_OUT_W + 2 + 7) / 8) * 8
)(
  input  logic                clk,
  input  logic                rst,
  input  lrupr_cmd_t          cmd,
  input  logic [IN_W-1:0]     s_tdata,
  output logic [OUT_W-1:0]    m_tdata,
  input  logic                cfg_we,
  input  logic [FRAMES_W-1:0] cfg_wdata,
  output logic [FRAMES_W-1:0] frames_in_use
);

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam logic [IDX_W-1:0] MAX_AGE = IDX_W'(FRAME_SLOTS - 1);

  logic [PAGE_BITS-1:0] slot_page [FRAME_SLOTS];
  logic [IDX_W-1:0]     slot_age  [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] slot_valid;
  logic [FAULT_W-1:0]   fault_total;
  logic [PAGE_BITS-1:0] req_page;

  // lookup decision
  logic             look_hit;
  logic             look_fill;
  logic [IDX_W-1:0] look_slot;
  logic [IDX_W-1:0] look_limit;

  // result register
  logic                 res_hit;
  logic [IDX_W-1:0]     res_slot;
  logic                 res_ev_valid;
  logic [PAGE_BITS-1:0] res_ev_page;

  logic [FRAME_SLOTS-1:0] active;
  logic [FRAME_SLOTS-1:0] match_v;
  logic [FRAME_SLOTS-1:0] empty_v;

  always_comb begin
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      active[i]  = (i == 0) || (int'(frames_in_use) > i);
      match_v[i] = active[i] && slot_valid[i] && (slot_page[i] == req_page);
      empty_v[i] = active[i] && !slot_valid[i];
    end
  end

  // lowest matching slot, lowest empty slot, lowest oldest slot
  logic             any_hit, any_empty;
  logic [IDX_W-1:0] hit_idx, empty_idx, old_idx, old_age;

  always_comb begin
    any_hit   = 1'b0;
    any_empty = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    old_idx   = '0;
    old_age   = '0;
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (empty_v[i]) begin
        any_empty = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (active[i] && (slot_age[i] > old_age)) begin
        old_age = slot_age[i];
        old_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_page <= s_tdata[PAGE_BITS-1:0];
    if (cmd.lookup) begin
      look_hit  <= any_hit;
      look_fill <= !any_hit && any_empty;
      if (any_hit) begin
        look_slot  <= hit_idx;
        look_limit <= slot_age[hit_idx];
      end else if (any_empty) begin
        look_slot  <= empty_idx;
        look_limit <= MAX_AGE;   // unused on fill
      end else begin
        look_slot  <= old_idx;
        look_limit <= old_age;
      end
    end
  end

  // slot table and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      fault_total   <= '0;
      frames_in_use <= FRAMES_RESET;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        slot_age[i]  <= '0;
        slot_page[i] <= '0;
      end
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
      slot_valid    <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        slot_age[i]  <= '0;
        slot_page[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        if (IDX_W'(i) == look_slot) begin
          slot_age[i] <= '0;
        end else if (active[i] && slot_valid[i] && (slot_age[i] < MAX_AGE) &&
                     (look_fill || (slot_age[i] < look_limit))) begin
          slot_age[i] <= slot_age[i] + 1'b1;
        end
      end
      if (!look_hit) begin
        slot_page[look_slot]  <= req_page;
        slot_valid[look_slot] <= 1'b1;
        if (fault_total != '1) fault_total <= fault_total + 1'b1;
      end
    end
  end

  // fault count shown is the value after this request
  logic [FAULT_W-1:0] res_fault;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_hit      <= look_hit;
      res_slot     <= look_slot;
      res_ev_valid <= !look_hit && !look_fill;
      res_ev_page  <= (!look_hit && !look_fill) ? slot_page[look_slot] : '0;
      res_fault    <= (!look_hit && (fault_total != '1)) ? fault_total + 1'b1 : fault_total;
    end
  end

  assign m_tdata = OUT_W'({res_fault, res_ev_page, res_ev_valid,
                           SLOT_OUT_W'(res_slot), res_hit});

endmodule

### rtl/lru_page_replacement.sv
// Top level: LRU page replacement engine with stream ports and an APB register port.
//
//  channel    dir    handshake          payload (low bit first)
//  s_*        in     tvalid/tready      tdata: page_number
//  m_*        out    tvalid/tready      tdata: hit, slot_used[2:0], evicted_valid,
//                                              evicted_page, fault_count[31:0]
//  apb        in     psel/penable       reg 0 (addr 0): frames_in_use[3:0]
//
//  Each request passes a lookup step (parallel tag compare, lowest empty
//  slot and oldest-slot search), then an update step (ages, slot fill,
//  fault counter, result register); the update step can take the next request.
//  A result waits in the output register; the next request is taken meanwhile,
//  and its update cycle holds while the previous result is still not taken.
//  Reset is synchronous; slots come up empty, no clearing pass is needed.
//  A write to frames_in_use empties all slots and keeps the fault total.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PAGE_BITS + FAULT_W + SLOT_OUT_W + 2 + 7) / 8) * 8
)(
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // page_number
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // hit, slot_used, evicted_valid,
                                           // evicted_page, fault_count
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  lrupr_cmd_t          cmd;
  logic                cfg_we;
  logic [FRAMES_W-1:0] frames_in_use;

  // register index is the word address; only index 0 exists
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_IDX_FRAMES);
  assign prdata = (paddr[2] == CFG_IDX_FRAMES) ? CFG_DATA_W'(frames_in_use) : '0;

  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lrupr_datapath #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .s_tdata       (s_tdata),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[FRAMES_W-1:0]),
    .frames_in_use (frames_in_use)
  );

endmodule
